// File: hw/rtl/cdq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the circular deque core.
// No dependencies; imported by cdq_cell and circular_deque_core.
package cdq_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam word_t WORD_NONE = '1;

endpackage

// File: hw/rtl/cdq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the circulating word ring.
// Depends on cdq_pkg for the word type.
module cdq_cell
    import cdq_pkg::*;
(
    input  logic  aclk,
    input  logic  load_en,
    input  word_t load_word,
    input  word_t shift_in,
    output word_t q
);

    word_t word_reg;
    word_t word_next;

    // Take the neighbor's word every cycle unless a new word is loaded here.
    assign word_next = load_en ? load_word : shift_in;

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

// File: hw/rtl/circular_deque_core.sv
`timescale 1ns / 1ps
// Channel | ports                       | direction | meaning
// s_      | s_valid s_ready s_kind s_value   | in  | one deque operation per word
// m_      | m_valid m_ready m_data m_status  | out | one result per operation
//
// Timing: an operation is taken, then waits until its entry passes the ring tap,
//   which the ring rotation over DEPTH cells sets. Refused pushes and pops from
//   empty do not wait for the tap.
// Reset: aresetn (synchronous, active low) clears indices, empty mark, control
//   and output valid. The ring contents are not cleared.
// Stalls: a finished result sits in the output register; the next word is taken
//   while it waits, and that word's result holds until m_ready frees the register.
//
// Storage is a ring of DEPTH cells that rotates by one cell each cycle. The cell
// at the tap (cell 0) holds the entry named by pos_reg. A read takes cell 0 when
// pos_reg hits the target entry; a write loads the last cell, which is where the
// tap entry lands on that same edge.
module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  word_t               s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output word_t               m_data,
    output logic [STATUS_W-1:0] m_status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    typedef enum logic {
        S_IDLE,
        S_SEEK
    } state_t;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic                empty_reg, empty_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [IDX_W-1:0]    tgt_reg, tgt_next;
    logic                wr_reg, wr_next;
    logic                rd_reg, rd_next;
    word_t               wdata_reg, wdata_next;
    status_t             status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    word_t               m_data_reg, m_data_next;
    status_t             m_status_reg, m_status_next;

    word_t               ring_q [DEPTH];
    logic                wr_hit;
    logic                hit;
    logic                out_free;
    logic                full;

    // Ring of cells; cell k shifts toward cell k-1, cell 0 wraps to the last cell.
    for (genvar k = 0; k < DEPTH; k++) begin : g_ring
        logic cell_load;
        if (k == DEPTH - 1) begin : g_tail
            assign cell_load = wr_hit;
        end else begin : g_body
            assign cell_load = 1'b0;
        end
        cdq_cell u_cell (
            .aclk      (aclk),
            .load_en   (cell_load),
            .load_word (wdata_reg),
            .shift_in  (ring_q[(k + 1) % DEPTH]),
            .q         (ring_q[k])
        );
    end

    assign hit      = (pos_reg == tgt_reg);
    assign wr_hit   = (state_reg == S_SEEK) && wr_reg && hit;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = !empty_reg && (idx_next(tail_reg) == head_reg);

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        tgt_next      = tgt_reg;
        wr_next       = wr_reg;
        rd_next       = rd_reg;
        wdata_next    = wdata_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        // The ring never stops; the tap index follows it.
        pos_next      = idx_next(pos_reg);

        // Drop the result once taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next  = S_SEEK;
                    wr_next     = 1'b0;
                    rd_next     = 1'b0;
                    wdata_next  = s_value;
                    status_next = ST_DONE;
                    case (kind_t'(s_kind))
                        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else if (empty_reg) begin
                                // First word always lands in entry 0.
                                wr_next    = 1'b1;
                                tgt_next   = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                            end else if (kind_t'(s_kind) == KIND_PUSH_FRONT) begin
                                wr_next   = 1'b1;
                                tgt_next  = idx_prev(head_reg);
                                head_next = idx_prev(head_reg);
                            end else begin
                                wr_next   = 1'b1;
                                tgt_next  = idx_next(tail_reg);
                                tail_next = idx_next(tail_reg);
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_REAR: begin
                            if (empty_reg) begin
                                status_next = ST_EMPTY;
                            end else begin
                                rd_next = 1'b1;
                                if (head_reg == tail_reg) begin
                                    // Last word out: back to the reset picture.
                                    tgt_next   = head_reg;
                                    head_next  = '0;
                                    tail_next  = '0;
                                    empty_next = 1'b1;
                                end else if (kind_t'(s_kind) == KIND_POP_FRONT) begin
                                    tgt_next  = head_reg;
                                    head_next = idx_next(head_reg);
                                end else begin
                                    tgt_next  = tail_reg;
                                    tail_next = idx_prev(tail_reg);
                                end
                            end
                        end
                        default: begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_SEEK: begin
                // Finish when the target entry is at the tap (or none is needed)
                // and the output register is free.
                if (((!wr_reg && !rd_reg) || hit) && out_free) begin
                    state_next    = S_IDLE;
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    if (rd_reg) begin
                        m_data_next = ring_q[0];
                    end else if (status_reg == ST_EMPTY) begin
                        m_data_next = WORD_NONE;
                    end else begin
                        m_data_next = '0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
            pos_reg      <= '0;
            wr_reg       <= 1'b0;
            rd_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            empty_reg    <= empty_next;
            pos_reg      <= pos_next;
            wr_reg       <= wr_next;
            rd_reg       <= rd_next;
            m_valid_reg  <= m_valid_next;
        end
        tgt_reg      <= tgt_next;
        wdata_reg    <= wdata_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

endmodule

// File: test/circular_deque_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for circular_deque_core: directed and random operations through valid/ready.
// A scoreboard class predicts each result. Depends on cdq_pkg and circular_deque_core.
module circular_deque_core_tb;
    import cdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off to back the core up
    localparam int RAND_PHASE  = 275;     // random words per idling phase
    localparam int LIMIT       = 200000;  // cycle budget for the whole run

    // Deque predictor plus in-order store of expected results.
    class deque_scoreboard;
        word_t   ring [DEPTH];
        int      head_pos;
        int      tail_pos;
        bit      is_empty;
        word_t   exp_data [$];
        status_t exp_status [$];
        int      errors;

        function new();
            head_pos = 0;
            tail_pos = 0;
            is_empty = 1'b1;
            errors   = 0;
        endfunction

        function int step_up(int i);
            return (i + 1 >= DEPTH) ? 0 : i + 1;
        endfunction

        function int step_down(int i);
            return (i == 0) ? DEPTH - 1 : i - 1;
        endfunction

        function int pending();
            return exp_data.size();
        endfunction

        // Apply one accepted operation and queue the result it must produce.
        function void note_op(kind_t op, word_t word);
            word_t   data;
            status_t status;
            data   = '0;
            status = ST_DONE;
            if (op == KIND_PUSH_FRONT || op == KIND_PUSH_REAR) begin
                if (!is_empty && step_up(tail_pos) == head_pos) begin
                    status = ST_FULL;
                end else if (is_empty) begin
                    head_pos = 0;
                    tail_pos = 0;
                    is_empty = 1'b0;
                    ring[0]  = word;
                end else if (op == KIND_PUSH_FRONT) begin
                    head_pos       = step_down(head_pos);
                    ring[head_pos] = word;
                end else begin
                    tail_pos       = step_up(tail_pos);
                    ring[tail_pos] = word;
                end
            end else if (is_empty) begin
                data   = WORD_NONE;
                status = ST_EMPTY;
            end else begin
                data = (op == KIND_POP_FRONT) ? ring[head_pos] : ring[tail_pos];
                if (head_pos == tail_pos) begin
                    head_pos = 0;
                    tail_pos = 0;
                    is_empty = 1'b1;
                end else if (op == KIND_POP_FRONT) begin
                    head_pos = step_up(head_pos);
                end else begin
                    tail_pos = step_down(tail_pos);
                end
            end
            exp_data.push_back(data);
            exp_status.push_back(status);
        endfunction

        // Compare one accepted result against the oldest expectation.
        function void check_result(word_t data, logic [STATUS_W-1:0] status);
            word_t   want_data;
            status_t want_status;
            if (exp_data.size() == 0) begin
                $display("%0t: result with nothing expected: data %0d status %0d",
                         $time, data, status);
                errors++;
                return;
            end
            want_data   = exp_data.pop_front();
            want_status = exp_status.pop_front();
            if (data !== want_data) begin
                $display("%0t: data mismatch: expected %0d actual %0d",
                         $time, want_data, data);
                errors++;
            end
            if (status !== want_status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want_status, status);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_valid  = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind   = '0;
    word_t               s_value  = '0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    word_t               m_data;
    logic [STATUS_W-1:0] m_status;

    deque_scoreboard board = new();

    // Idling knobs, changed between phases by the stimulus process.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    int cycle_count   = 0;

    // Corner words: sign extremes, zero, all ones, one, alternating bit patterns and a low-half mask.
    word_t corner_words [8] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'shFFFFFFFF,
                                32'sh00000001, 32'sh55555555, 32'shAAAAAAAA, 32'sh0000FFFF};

    circular_deque_core #(
        .DEPTH(DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .s_value (s_value),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .m_status(m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Kill a hung run; the budget covers the slowest idling phase several times over.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one word and hold it until the core takes it. Keep valid high across
    // back-to-back words; drop it only when an idle gap is chosen.
    task automatic send_op(input kind_t op, input word_t word);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_kind  <= op;
        s_value <= word;
        do @(posedge aclk); while (!s_ready);
        board.note_op(op, word);
    endtask

    // Result side: check every accepted word, then pick the next ready level.
    // On request, hold ready low for a long stretch so the core fills and stalls.
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                board.check_result(m_data, m_status);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : stimulus
        int    i;
        int    phase;
        int    push_pct;
        kind_t op;
        word_t word;

        // Hold reset low at the start, then release it once.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Pops from an empty queue.
        send_op(KIND_POP_FRONT, 32'sh5A5A5A5A);
        send_op(KIND_POP_REAR, 32'sh5A5A5A5A);
        // Push onto empty, then remove that last item from each end.
        send_op(KIND_PUSH_FRONT, 32'sh7FFFFFFF);
        send_op(KIND_POP_REAR, '0);
        send_op(KIND_PUSH_REAR, 32'sh80000000);
        send_op(KIND_POP_FRONT, '0);
        // Fill to DEPTH from both ends so the head index wraps.
        for (i = 0; i < DEPTH; i++) begin
            send_op(i[0] ? KIND_PUSH_REAR : KIND_PUSH_FRONT, corner_words[i % 8]);
        end
        // Pushes refused while full, then pops from a full queue.
        send_op(KIND_PUSH_FRONT, 32'sh12345678);
        send_op(KIND_PUSH_REAR, 32'shFEDCBA98);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_POP_REAR, '0);

        // Random part: four idling phases. Inside each, blocks of 40 words lean toward
        // pushes, toward pops or neither, so the fill level sweeps from empty to full.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_req      = 1'b1;
                end
                1: begin
                    send_idle_pct = 81;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 81;
                end
                default: begin
                    send_idle_pct = 11;
                    stall_pct     = 11;
                end
            endcase
            push_pct = 85;
            for (i = 0; i < RAND_PHASE; i++) begin
                if (i % 40 == 0 && i != 0) begin
                    case ($urandom_range(2))
                        0:       push_pct = 15;
                        1:       push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                if ($urandom_range(99) < push_pct) begin
                    op = $urandom_range(1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
                end else begin
                    op = $urandom_range(1) ? KIND_POP_REAR : KIND_POP_FRONT;
                end
                if ($urandom_range(7) == 0) begin
                    word = corner_words[$urandom_range(7)];
                end else begin
                    word = word_t'($urandom);
                end
                send_op(op, word);
            end
        end
        s_valid <= 1'b0;

        // Drain: wait for every expected word, then allow one full ring rotation
        // for anything stray.
        while (board.pending() != 0) @(posedge aclk);
        repeat (DEPTH + 4) @(posedge aclk);

        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
